### sv/fetc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and constant tables for the FET-style compressor.
// No dependencies; imported by fetc_mul, fet_compressor_sample and the testbench.
package fetc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MUL_W    = 34;
  localparam int PROD_W   = 2 * MUL_W;

  // configuration register indexes
  localparam logic [2:0] REG_THRESH  = 3'd0;
  localparam logic [2:0] REG_SCALE   = 3'd1;
  localparam logic [2:0] REG_RATIO   = 3'd2;
  localparam logic [2:0] REG_MAKEUP  = 3'd3;
  localparam logic [2:0] REG_WET     = 3'd4;
  localparam logic [2:0] REG_RMS     = 3'd5;
  localparam logic [2:0] REG_ATTACK  = 3'd6;
  localparam logic [2:0] REG_RELEASE = 3'd7;

  // ratio select codes
  localparam logic [2:0] RSEL_4   = 3'd0;
  localparam logic [2:0] RSEL_8   = 3'd1;
  localparam logic [2:0] RSEL_12  = 3'd2;
  localparam logic [2:0] RSEL_20  = 3'd3;
  localparam logic [2:0] RSEL_ALL = 3'd4;
  localparam logic [2:0] RSEL_4B  = 3'd5;
  localparam logic [2:0] RSEL_8B  = 3'd6;
  localparam logic [2:0] RSEL_12B = 3'd7;

  // fixed-point constants (Q.16 unless noted; WET_FULL is 1.0 in Q.15)
  localparam logic [24:0] ONE_Q16      = 25'h0_10000;
  localparam logic [24:0] RATIO4_Q16   = 25'h0_40000;
  localparam logic [24:0] RATIO8_Q16   = 25'h0_80000;
  localparam logic [24:0] RATIO12_Q16  = 25'h0_C0000;
  localparam logic [24:0] RATIO20_Q16  = 25'h1_40000;
  localparam int          DB5_Q16      = 327680;
  localparam logic [15:0] LN2_Q16      = 16'd45426;
  localparam logic [15:0] L2_DB_Q16    = 16'd10885;
  localparam logic [15:0] WET_FULL     = 16'd32768;

  // floor square root of a 64-bit value (elaboration only)
  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // 2^(-2^-k) in Q0.32, formed by k truncated square roots of one half
  function automatic logic [31:0] pow_root(input int k);
    logic [63:0] v;
    v = 64'h0000_0000_8000_0000;
    for (int j = 0; j < k; j++) begin
      v = {32'd0, isqrt64({v[31:0], 32'd0})};
    end
    return v[31:0];
  endfunction

  localparam logic [31:0] POW_TAB [16] = '{
    pow_root(1),  pow_root(2),  pow_root(3),  pow_root(4),
    pow_root(5),  pow_root(6),  pow_root(7),  pow_root(8),
    pow_root(9),  pow_root(10), pow_root(11), pow_root(12),
    pow_root(13), pow_root(14), pow_root(15), pow_root(16)
  };

endpackage

### sv/fetc_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with operand and product registers.
// Depends on fetc_pkg for the operand width.
module fetc_mul
  import fetc_pkg::*;
(
  input  logic                     clk,
  input  logic                     ld,
  input  logic signed [MUL_W-1:0]  a_in,
  input  logic signed [MUL_W-1:0]  b_in,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [MUL_W-1:0] a_r;
  logic signed [MUL_W-1:0] b_r;

  // capture operands on ld; the product register follows in the next cycle
  always_ff @(posedge clk) begin
    if (ld) begin
      a_r <= a_in;
      b_r <= b_in;
    end
    prod_r <= a_r * b_r;
  end

endmodule

### sv/fet_compressor_sample.sv
`timescale 1ns / 1ps
// Top level of the FET-style RMS compressor: sequencer and datapath.
// Depends on fetc_pkg and fetc_mul.
//
// Usage:
//  - in_* is a stream slave carrying one signed 16-bit sample per beat.
//  - out_* is a stream master carrying one compressed, mixed sample per beat.
//  - cfg_* writes register cfg_addr with cfg_wdata whenever cfg_we is high;
//    write only while the block is idle.
//  - Every sample walks through one shared 34x34 multiplier under a sequencer:
//    a 16-step square root, a normalize loop of up to 9 steps, 16 log
//    squarings, a 16-step ratio divide and up to 15 exp products. The log
//    pass is skipped when the level is at or below threshold, and exp
//    products come only from set fraction bits.
//  - in_tready is high only while the sequencer is idle; a new sample is
//    taken while the previous result still waits in the output register.
//  - If the receiver stalls, the finished sample waits in the last step until
//    the output register frees.
//  - Reset loads the default register values and clears the mean square,
//    smoothed level and smoothed ratio; no result is pending after reset.
module fet_compressor_sample
  import fetc_pkg::*;
#(
  parameter int unsigned RATIO_ATTACK_COEF  = 869000,
  parameter int unsigned RATIO_RELEASE_COEF = 8388228
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_MUL  = 5'd1;
  localparam logic [4:0] ST_SQ   = 5'd2;
  localparam logic [4:0] ST_MS   = 5'd3;
  localparam logic [4:0] ST_SQRT = 5'd4;
  localparam logic [4:0] ST_P    = 5'd5;
  localparam logic [4:0] ST_NORM = 5'd6;
  localparam logic [4:0] ST_LOG  = 5'd7;
  localparam logic [4:0] ST_LN   = 5'd8;
  localparam logic [4:0] ST_OV   = 5'd9;
  localparam logic [4:0] ST_SM0  = 5'd10;
  localparam logic [4:0] ST_SM1  = 5'd11;
  localparam logic [4:0] ST_SM2  = 5'd12;
  localparam logic [4:0] ST_DIV  = 5'd13;
  localparam logic [4:0] ST_G    = 5'd14;
  localparam logic [4:0] ST_T    = 5'd15;
  localparam logic [4:0] ST_POW  = 5'd16;
  localparam logic [4:0] ST_PACC = 5'd17;
  localparam logic [4:0] ST_GM0  = 5'd18;
  localparam logic [4:0] ST_GM1  = 5'd19;
  localparam logic [4:0] ST_W1   = 5'd20;
  localparam logic [4:0] ST_W2   = 5'd21;
  localparam logic [4:0] ST_OUT  = 5'd22;

  // configuration registers
  logic [23:0] thr_r;
  logic [15:0] scale_r;
  logic [2:0]  rsel_r;
  logic [15:0] makeup_r;
  logic [15:0] wet_r;
  logic [22:0] rms_r;
  logic [22:0] att_r;
  logic [22:0] rel_r;

  // sequencer and datapath registers
  logic [4:0]  st_r, st_nxt, ret_r, ret_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  ip_r, ip_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic [31:0] ms_r, ms_nxt;
  logic [23:0] sod_r, sod_nxt;
  logic [23:0] sr_r, sr_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [39:0] w_r, w_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [22:0] over_r, over_nxt;
  logic [24:0] d_r, d_nxt;
  logic [23:0] tgt_r, tgt_nxt;
  logic [24:0] r_r, r_nxt;
  logic [7:0]  n_r, n_nxt;
  logic [32:0] acc_r, acc_nxt;
  logic [33:0] hp_r, hp_nxt;
  logic [15:0] out_r, out_nxt;
  logic        ovld_r, ovld_nxt;

  // shared multiplier
  logic                     mul_ld;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  fetc_mul u_mul (
    .clk    (clk),
    .ld     (mul_ld),
    .a_in   (mul_a),
    .b_in   (mul_b),
    .prod_r (mul_p)
  );

  logic in_fire;
  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = out_r;

  // derived mix fractions
  logic [15:0] wet_c, dry_c;
  assign wet_c = (wet_r > WET_FULL) ? WET_FULL : wet_r;
  assign dry_c = WET_FULL - wet_c;

  // datapath temporaries
  logic [31:0]        sq_t;
  logic signed [33:0] ms_sum;
  logic [17:0]        sr_rem, sr_trial;
  logic               sr_ge;
  logic [39:0]        p_t;
  logic [31:0]        m2_t;
  logic [30:0]        m_t;
  logic [19:0]        ln_t;
  logic signed [24:0] d_t;
  logic signed [25:0] sod_sum, sr_sum;
  logic signed [24:0] rd_t;
  logic [25:0]        dv_rem2;
  logic               dv_ge;
  logic [32:0]        gain_t;
  logic [35:0]        gm_t;
  logic [51:0]        tot_t;
  logic [29:0]        c_t;
  logic [45:0]        s_t, smag_t;
  logic [21:0]        q_t;
  logic [3:0]         pidx;

  always_comb begin
    st_nxt   = st_r;
    ret_nxt  = ret_r;
    cnt_nxt  = cnt_r;
    ip_nxt   = ip_r;
    x_nxt    = x_r;
    ms_nxt   = ms_r;
    sod_nxt  = sod_r;
    sr_nxt   = sr_r;
    sq_nxt   = sq_r;
    w_nxt    = w_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bits_nxt = bits_r;
    over_nxt = over_r;
    d_nxt    = d_r;
    tgt_nxt  = tgt_r;
    r_nxt    = r_r;
    n_nxt    = n_r;
    acc_nxt  = acc_r;
    hp_nxt   = hp_r;
    out_nxt  = out_r;
    ovld_nxt = ovld_r;
    mul_ld   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;

    sq_t     = mul_p[30] ? 32'hFFFF_FFFF : {mul_p[29:0], 2'b00};
    ms_sum   = $signed({2'b00, sq_r}) + $signed(mul_p[56:23]);
    sr_rem   = {rem_r[15:0], w_r[31:30]};
    sr_trial = {root_r, 2'b01};
    sr_ge    = (sr_rem >= sr_trial);
    p_t      = mul_p[39:0];
    m2_t     = mul_p[61:30];
    m_t      = m2_t[31] ? m2_t[31:1] : m2_t[30:0];
    ln_t     = mul_p[35:16];
    d_t      = $signed({1'b0, sod_r}) - $signed({2'b00, over_r});
    sod_sum  = $signed({3'b000, over_r}) + $signed(mul_p[48:23]);
    sr_sum   = $signed({2'b00, tgt_r}) + $signed(mul_p[48:23]);
    rd_t     = $signed({1'b0, sr_r}) - $signed({1'b0, tgt_r});
    dv_rem2  = {rem_r[24:0], 1'b0};
    dv_ge    = (dv_rem2 >= {1'b0, r_r});
    gain_t   = (n_r >= 8'd33) ? 33'd0 : (acc_r >> n_r[5:0]);
    gm_t     = mul_p[47:12];
    tot_t    = {hp_r, 18'd0} + mul_p[51:0];
    c_t      = {1'b0, tot_t[51:23]} + {5'd0, dry_c, 9'd0};
    s_t      = mul_p[45:0];
    smag_t   = s_t[45] ? (~s_t + 46'd1) : s_t;
    q_t      = smag_t[45:24];
    pidx     = ~cnt_r;

    case (st_r)
      // take a sample, square it
      ST_IDLE: begin
        if (in_fire) begin
          x_nxt   = $signed(in_tdata);
          mul_ld  = 1'b1;
          mul_a   = MUL_W'($signed(in_tdata));
          mul_b   = MUL_W'($signed(in_tdata));
          ret_nxt = ST_SQ;
          st_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        st_nxt = ret_r;
      end
      // scale the square, issue the mean-square pole
      ST_SQ: begin
        sq_nxt  = sq_t;
        mul_ld  = 1'b1;
        mul_a   = $signed({2'b00, ms_r}) - $signed({2'b00, sq_t});
        mul_b   = $signed({11'd0, rms_r});
        ret_nxt = ST_MS;
        st_nxt  = ST_MUL;
      end
      // update mean square, start square root
      ST_MS: begin
        ms_nxt   = ms_sum[31:0];
        w_nxt    = {8'd0, ms_sum[31:0]};
        rem_nxt  = '0;
        root_nxt = '0;
        cnt_nxt  = 4'd15;
        st_nxt   = ST_SQRT;
      end
      // one root bit per cycle
      ST_SQRT: begin
        rem_nxt  = {8'd0, sr_ge ? (sr_rem - sr_trial) : sr_rem};
        root_nxt = {root_r[14:0], sr_ge};
        w_nxt    = {w_r[37:0], 2'b00};
        if (cnt_r == 4'd0) begin
          mul_ld  = 1'b1;
          mul_a   = $signed({18'd0, root_r[14:0], sr_ge});
          mul_b   = $signed({10'd0, thr_r});
          ret_nxt = ST_P;
          st_nxt  = ST_MUL;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      // level against threshold
      ST_P: begin
        if (p_t > 40'h00_4000_0000) begin
          w_nxt  = p_t;
          ip_nxt = '0;
          st_nxt = ST_NORM;
        end else begin
          over_nxt = '0;
          st_nxt   = ST_SM0;
        end
      end
      // shift the mantissa down into [1,2)
      ST_NORM: begin
        if (|w_r[39:31]) begin
          w_nxt  = {1'b0, w_r[39:1]};
          ip_nxt = ip_r + 4'd1;
        end else begin
          bits_nxt = '0;
          cnt_nxt  = 4'd15;
          mul_ld   = 1'b1;
          mul_a    = $signed({3'd0, w_r[30:0]});
          mul_b    = $signed({3'd0, w_r[30:0]});
          ret_nxt  = ST_LOG;
          st_nxt   = ST_MUL;
        end
      end
      // one fraction bit of log2 per squaring
      ST_LOG: begin
        bits_nxt = {bits_r[14:0], m2_t[31]};
        w_nxt    = {9'd0, m_t};
        mul_ld   = 1'b1;
        st_nxt   = ST_MUL;
        if (cnt_r == 4'd0) begin
          mul_a   = $signed({14'd0, ip_r, bits_r[14:0], m2_t[31]});
          mul_b   = $signed({18'd0, LN2_Q16});
          ret_nxt = ST_LN;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
          mul_a   = $signed({3'd0, m_t});
          mul_b   = $signed({3'd0, m_t});
          ret_nxt = ST_LOG;
        end
      end
      ST_LN: begin
        mul_ld  = 1'b1;
        mul_a   = $signed({14'd0, ln_t});
        mul_b   = $signed({18'd0, scale_r});
        ret_nxt = ST_OV;
        st_nxt  = ST_MUL;
      end
      // saturate dB over threshold
      ST_OV: begin
        over_nxt = (|mul_p[35:31]) ? 23'h7F_FFFF : mul_p[30:8];
        st_nxt   = ST_SM0;
      end
      // choose pole and ratio target, smooth level
      ST_SM0: begin
        d_nxt   = d_t;
        tgt_nxt = (d_t < -25'sd327680) ? RATIO4_Q16[23:0] : sr_r;
        mul_ld  = 1'b1;
        mul_a   = MUL_W'(d_t);
        mul_b   = d_t[24] ? $signed({11'd0, att_r}) : $signed({11'd0, rel_r});
        ret_nxt = ST_SM1;
        st_nxt  = ST_MUL;
      end
      ST_SM1: begin
        sod_nxt = sod_sum[23:0];
        mul_ld  = 1'b1;
        mul_a   = MUL_W'(rd_t);
        mul_b   = d_r[24] ? $signed(MUL_W'(RATIO_ATTACK_COEF))
                          : $signed(MUL_W'(RATIO_RELEASE_COEF));
        ret_nxt = ST_SM2;
        st_nxt  = ST_MUL;
      end
      // update ratio, pick effective ratio, start divide
      ST_SM2: begin
        sr_nxt = sr_sum[23:0];
        case (rsel_r)
          RSEL_8, RSEL_8B:   r_nxt = RATIO8_Q16;
          RSEL_12, RSEL_12B: r_nxt = RATIO12_Q16;
          RSEL_20:           r_nxt = RATIO20_Q16;
          RSEL_ALL:          r_nxt = RATIO12_Q16 + {1'b0, sr_sum[23:0]};
          default:           r_nxt = RATIO4_Q16;
        endcase
        rem_nxt  = {1'b0, r_nxt - ONE_Q16};
        bits_nxt = '0;
        cnt_nxt  = 4'd15;
        st_nxt   = ST_DIV;
      end
      // one quotient bit of (r-1)/r per cycle
      ST_DIV: begin
        rem_nxt  = dv_ge ? (dv_rem2 - {1'b0, r_r}) : dv_rem2;
        bits_nxt = {bits_r[14:0], dv_ge};
        if (cnt_r == 4'd0) begin
          mul_ld  = 1'b1;
          mul_a   = $signed({10'd0, sod_r});
          mul_b   = $signed({18'd0, bits_r[14:0], dv_ge});
          ret_nxt = ST_G;
          st_nxt  = ST_MUL;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      ST_G: begin
        mul_ld  = 1'b1;
        mul_a   = $signed({10'd0, mul_p[39:16]});
        mul_b   = $signed({18'd0, L2_DB_Q16});
        ret_nxt = ST_T;
        st_nxt  = ST_MUL;
      end
      // split exponent into shift and fraction
      ST_T: begin
        n_nxt    = mul_p[39:32];
        bits_nxt = mul_p[31:16];
        acc_nxt  = 33'h1_0000_0000;
        cnt_nxt  = 4'd15;
        st_nxt   = ST_POW;
      end
      // fold in one root factor per set fraction bit
      ST_POW: begin
        if (bits_r[15] && !acc_r[32]) begin
          mul_ld  = 1'b1;
          mul_a   = $signed({1'b0, acc_r});
          mul_b   = $signed({2'd0, POW_TAB[pidx]});
          ret_nxt = ST_PACC;
          st_nxt  = ST_MUL;
        end else begin
          if (bits_r[15]) begin
            acc_nxt = {1'b0, POW_TAB[pidx]};
          end
          bits_nxt = {bits_r[14:0], 1'b0};
          if (cnt_r == 4'd0) begin
            st_nxt = ST_GM0;
          end else begin
            cnt_nxt = cnt_r - 4'd1;
          end
        end
      end
      ST_PACC: begin
        acc_nxt  = {1'b0, mul_p[63:32]};
        bits_nxt = {bits_r[14:0], 1'b0};
        if (cnt_r == 4'd0) begin
          st_nxt = ST_GM0;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
          st_nxt  = ST_POW;
        end
      end
      // apply makeup gain
      ST_GM0: begin
        mul_ld  = 1'b1;
        mul_a   = $signed({1'b0, gain_t});
        mul_b   = $signed({18'd0, makeup_r});
        ret_nxt = ST_GM1;
        st_nxt  = ST_MUL;
      end
      // wet product in two halves
      ST_GM1: begin
        w_nxt   = {4'd0, gm_t};
        mul_ld  = 1'b1;
        mul_a   = $signed({16'd0, gm_t[35:18]});
        mul_b   = $signed({18'd0, wet_c});
        ret_nxt = ST_W1;
        st_nxt  = ST_MUL;
      end
      ST_W1: begin
        hp_nxt  = mul_p[33:0];
        mul_ld  = 1'b1;
        mul_a   = $signed({16'd0, w_r[17:0]});
        mul_b   = $signed({18'd0, wet_c});
        ret_nxt = ST_W2;
        st_nxt  = ST_MUL;
      end
      // total wet plus dry gain times sample
      ST_W2: begin
        mul_ld  = 1'b1;
        mul_a   = MUL_W'(x_r);
        mul_b   = $signed({4'd0, c_t});
        ret_nxt = ST_OUT;
        st_nxt  = ST_MUL;
      end
      // truncate toward zero, saturate, hold until the output frees
      ST_OUT: begin
        if (!ovld_r || out_tready) begin
          if (!s_t[45]) begin
            out_nxt = (q_t > 22'd32767) ? 16'h7FFF : q_t[15:0];
          end else begin
            out_nxt = (q_t > 22'd32768) ? 16'h8000 : (~q_t[15:0] + 16'd1);
          end
          ovld_nxt = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // drop the result once taken, unless a new one replaces it
    if (ovld_r && out_tready && !(st_r == ST_OUT)) begin
      ovld_nxt = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ret_r  <= ST_IDLE;
      cnt_r  <= '0;
      ms_r   <= '0;
      sod_r  <= '0;
      sr_r   <= '0;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ret_r  <= ret_nxt;
      cnt_r  <= cnt_nxt;
      ms_r   <= ms_nxt;
      sod_r  <= sod_nxt;
      sr_r   <= sr_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ip_r   <= ip_nxt;
    x_r    <= x_nxt;
    sq_r   <= sq_nxt;
    w_r    <= w_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bits_r <= bits_nxt;
    over_r <= over_nxt;
    d_r    <= d_nxt;
    tgt_r  <= tgt_nxt;
    r_r    <= r_nxt;
    n_r    <= n_nxt;
    acc_r  <= acc_nxt;
    hp_r   <= hp_nxt;
    out_r  <= out_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= 24'd32690;
      scale_r  <= 16'd2224;
      rsel_r   <= RSEL_ALL;
      makeup_r <= 16'd4096;
      wet_r    <= 16'd32768;
      rms_r    <= 23'd8380219;
      att_r    <= 23'd2699500;
      rel_r    <= 23'd8384805;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESH:  thr_r    <= cfg_wdata;
        REG_SCALE:   scale_r  <= cfg_wdata[15:0];
        REG_RATIO:   rsel_r   <= cfg_wdata[2:0];
        REG_MAKEUP:  makeup_r <= cfg_wdata[15:0];
        REG_WET:     wet_r    <= cfg_wdata[15:0];
        REG_RMS:     rms_r    <= cfg_wdata[22:0];
        REG_ATTACK:  att_r    <= cfg_wdata[22:0];
        REG_RELEASE: rel_r    <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  // smoothed level never leaves the saturated over-threshold range
  a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
    sod_r[23] == 1'b0)
    else $error("smoothed level out of range");

  // smoothed ratio never rises above 4.0
  a_sr_range: assert property (@(posedge clk) disable iff (!rst_n)
    sr_r <= RATIO4_Q16[23:0])
    else $error("smoothed ratio above 4.0");

  // divide remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (rem_r < {1'b0, r_r}))
    else $error("ratio divide remainder too large");

  // an accepted sample goes straight to the multiplier
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (st_r == ST_MUL && ret_r == ST_SQ))
    else $error("accepted sample not issued");

endmodule

### tb/sv/fet_compressor_sample_check.sv
`timescale 1ns / 1ps
// Scoreboard for fet_compressor_sample: watches the in, out and cfg ports,
// predicts each output sample from a shadow of the registers and the detector
// state, and counts mismatches. Depends on fetc_pkg.
module fet_compressor_sample_check
  import fetc_pkg::*;
#(
  parameter longint RATIO_ATTACK_COEF  = 869000,
  parameter longint RATIO_RELEASE_COEF = 8388228
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  // register shadows
  logic [63:0] thresh_recip, det_scale, makeup, wet_frac, rms_pole, atk_pole, rel_pole;
  logic [2:0]  ratio_sel;
  // detector state
  logic [31:0] mean_sq;
  longint      level_db;
  longint      adapt_ratio;

  logic [15:0] sample_q[$];

  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [63:0] rem, res, b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    while (b > rem && b != 0) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // 2^(-t), t in Q.16, result Q1.32
  function automatic logic [63:0] exp2_neg(logic [63:0] t);
    logic [63:0] acc, v;
    acc = 64'd1 << 32;
    v   = 64'd1 << 31;
    for (int i = 1; i <= 16; i++) begin
      v = {32'd0, floor_root(v << 32)};
      if (t[16 - i]) acc = (acc * v) >> 32;
    end
    if ((t >> 16) >= 33) return '0;
    return acc >> (t >> 16);
  endfunction

  // advance the detector by one sample and return the output sample
  function automatic logic [15:0] compress_sample(logic signed [15:0] x);
    logic [63:0] sq, det, prod, mant, frac, l2, ln, over, r, k, g, t, gain, wet, dry, gw;
    longint      xs, diff, d, target, coef, rcoef, sum, res;
    int          e;
    xs = x;
    sq = xs * xs;
    sq = (sq >= (64'd1 << 30)) ? 64'hFFFF_FFFF : (sq << 2);

    diff    = longint'({32'd0, mean_sq}) - longint'(sq);
    mean_sq = 32'(longint'(sq) + ((longint'(rms_pole) * diff) >>> 23));

    // level over threshold in dB
    over = '0;
    det  = {32'd0, floor_root({32'd0, mean_sq})};
    prod = det * thresh_recip;
    if (prod > (64'd1 << 30)) begin
      e = 63;
      while (e > 0 && !prod[e]) e--;
      mant = prod >> (e - 30);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
        mant = (mant * mant) >> 30;
        frac = frac << 1;
        if (mant >= (64'd1 << 31)) begin
          mant = mant >> 1;
          frac = frac | 64'd1;
        end
      end
      l2   = (64'(e - 30) << 16) | frac;
      ln   = (l2 * LN2_Q16) >> 16;
      over = (det_scale * ln) >> 8;
      if (over > 64'h7F_FFFF) over = 64'h7F_FFFF;
    end

    // attack or release smoothing; a fast rise snaps the ratio target to 4
    d      = level_db - longint'(over);
    target = (d < -DB5_Q16) ? longint'(RATIO4_Q16) : adapt_ratio;
    if (d < 0) begin
      coef  = longint'(atk_pole);
      rcoef = RATIO_ATTACK_COEF;
    end else begin
      coef  = longint'(rel_pole);
      rcoef = RATIO_RELEASE_COEF;
    end
    level_db    = longint'(over) + ((coef * d) >>> 23);
    adapt_ratio = target + ((rcoef * (adapt_ratio - target)) >>> 23);

    case (ratio_sel)
      RSEL_8, RSEL_8B:   r = RATIO8_Q16;
      RSEL_12, RSEL_12B: r = RATIO12_Q16;
      RSEL_20:           r = RATIO20_Q16;
      RSEL_ALL:          r = 64'(RATIO12_Q16) + 64'(adapt_ratio);
      default:           r = RATIO4_Q16;
    endcase
    k    = (r > ONE_Q16) ? ((r - ONE_Q16) << 16) / r : 64'd0;
    g    = (64'(level_db) * k) >> 16;
    t    = (g * L2_DB_Q16) >> 16;
    gain = exp2_neg(t);

    // makeup, wet/dry mix, saturate
    wet = (wet_frac > WET_FULL) ? 64'(WET_FULL) : wet_frac;
    dry = 64'(WET_FULL) - wet;
    gw  = ((((gain * makeup) >> 12) * wet) >> 15) >> 8;
    sum = xs * longint'(gw) + xs * longint'(dry << 9);
    res = sum / (longint'(1) << 24);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return 16'(res);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thresh_recip = 32690;
      det_scale    = 2224;
      ratio_sel    = RSEL_ALL;
      makeup       = 4096;
      wet_frac     = 32768;
      rms_pole     = 8380219;
      atk_pole     = 2699500;
      rel_pole     = 8384805;
      mean_sq      = '0;
      level_db     = 0;
      adapt_ratio  = 0;
      sample_q.delete();
    end else begin
      // mirror register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_THRESH:  thresh_recip = {40'd0, cfg_wdata};
          REG_SCALE:   det_scale    = {48'd0, cfg_wdata[15:0]};
          REG_RATIO:   ratio_sel    = cfg_wdata[2:0];
          REG_MAKEUP:  makeup       = {48'd0, cfg_wdata[15:0]};
          REG_WET:     wet_frac     = {48'd0, cfg_wdata[15:0]};
          REG_RMS:     rms_pole     = {41'd0, cfg_wdata[22:0]};
          REG_ATTACK:  atk_pole     = {41'd0, cfg_wdata[22:0]};
          REG_RELEASE: rel_pole     = {41'd0, cfg_wdata[22:0]};
          default: ;
        endcase
      end
      // compare output beats in order
      if (out_tvalid && out_tready) begin
        if (sample_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output beat, expected none, actual %0d",
                   $time, $signed(out_tdata));
        end else begin
          logic [15:0] exp_s;
          exp_s = sample_q.pop_front();
          if (exp_s !== out_tdata) begin
            errors++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, $signed(exp_s), $signed(out_tdata));
          end
        end
      end
      if (in_tvalid && in_tready) sample_q.push_back(compress_sample(in_tdata));
    end
    pending = sample_q.size();
  end

  initial begin
    errors  = 0;
    pending = 0;
  end

endmodule

### tb/sv/fet_compressor_sample_test.sv
`timescale 1ns / 1ps
// Top of the fet_compressor_sample testbench: clock, reset, sample and
// register stimulus, receiver back-pressure and verdict.
// Depends on fetc_pkg, fet_compressor_sample and fet_compressor_sample_check.
module fet_compressor_sample_test;
  import fetc_pkg::*;

  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int PHASE_BEATS = 116;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] sample_in
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] sample_out
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  int   errors;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_req;
  logic hold_seen;
  int   hold_cnt;
  int   cycles;

  fet_compressor_sample dut (.*);

  fet_compressor_sample_check check (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("fet_compressor_sample_test: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt  = 1500;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // pulse the write enable for one cycle, then lower it before returning
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // offer one sample, holding valid until the beat is taken
  task automatic send_sample(logic [15:0] s);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    // in_tready only moves at the rising edge, so the value seen here is the
    // one the next rising edge samples
    do begin
      taken = in_tready;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // amplitude-banded random sample; band 0 covers every bit pattern
  function automatic logic [15:0] band_sample(int band);
    int amp;
    case (band)
      0:       return 16'($urandom_range(65535));
      1:       amp = 32767;
      2:       amp = 6000;
      3:       amp = 400;
      default: amp = 12;
    endcase
    return 16'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  function automatic logic [23:0] pick_coef();
    case ($urandom_range(3))
      0:       return 24'd0;
      1:       return 24'h7F_FFFF;
      2:       return 24'(8388607 - $urandom_range(20000));
      default: return 24'($urandom_range(24'hFF_FFFF));
    endcase
  endfunction

  initial begin
    int band, run;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_we         = 1'b0;
    cfg_addr       = REG_THRESH;
    cfg_wdata      = '0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    hold_seen      = 1'b0;
    hold_cnt       = 0;
    cycles         = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes at default settings
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(-16'sd32768);
    drain();

    // every ratio select, loud then quiet
    for (int rs = 0; rs < 8; rs++) begin
      write_reg(REG_RATIO, 24'(rs));
      send_sample(16'sd32767);
      send_sample(16'sd3);
      drain();
    end

    // wet above one, threshold extremes, heavy gain reduction, full makeup
    write_reg(REG_WET, 24'hFF_FFFF);
    write_reg(REG_THRESH, 24'd0);
    write_reg(REG_MAKEUP, 24'h00_FFFF);
    send_sample(-16'sd32768);
    drain();
    write_reg(REG_THRESH, 24'hFF_FFFF);
    write_reg(REG_SCALE, 24'h00_FFFF);
    write_reg(REG_RATIO, 24'(RSEL_20));
    write_reg(REG_RMS, 24'd0);
    write_reg(REG_ATTACK, 24'd0);
    write_reg(REG_RELEASE, 24'h7F_FFFF);
    send_sample(16'sd32767);
    send_sample(-16'sd20000);
    send_sample(16'sd5);
    drain();

    // random phases, each under its own settings and idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_THRESH, ($urandom_range(3) == 0) ? 24'd32690 :
                            ($urandom_range(3) == 0) ? 24'hFF_FFFF :
                            24'($urandom_range(24'hFF_FFFF)));
      write_reg(REG_SCALE, ($urandom_range(3) == 0) ? 24'd2224 :
                           24'($urandom_range(24'hFF_FFFF)));
      write_reg(REG_RATIO, 24'($urandom_range(24'hFF_FFFF)));
      write_reg(REG_MAKEUP, ($urandom_range(1) == 0) ? 24'd4096 :
                            24'($urandom_range(24'hFF_FFFF)));
      write_reg(REG_WET, ($urandom_range(2) == 0) ? 24'd32768 :
                         ($urandom_range(2) == 0) ? 24'd0 :
                         24'($urandom_range(24'hFF_FFFF)));
      write_reg(REG_RMS, pick_coef());
      write_reg(REG_ATTACK, pick_coef());
      write_reg(REG_RELEASE, pick_coef());

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase

      // long receiver hold-off while samples keep coming
      if (ph == 0) hold_req <= ~hold_req;

      band = 0;
      run  = 0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // tone-burst segments: each run of samples keeps one random amplitude band
        if (run == 0) begin
          band = $urandom_range(4);
          run  = $urandom_range(4, 20);
        end
        run--;
        if (ph == 5 && n == PHASE_BEATS / 2) drain();
        send_sample(band_sample(band));
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("fet_compressor_sample_test: done, clean");
    end else begin
      $display("fet_compressor_sample_test: done, errors");
    end
    $finish;
  end

endmodule
